>>> rtl/nrc_pkg.sv
`default_nettype none

package nrc_pkg;

  // operation codes of the command channel
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CUR_THRESH = 2'd0;
  localparam logic [1:0] REG_VOLT_UPPER = 2'd1;
  localparam logic [1:0] REG_VOLT_LOWER = 2'd2;
  localparam logic [1:0] REG_ROUTERS    = 2'd3;

  localparam logic [7:0] CUR_THRESH_RST = 8'd20;
  localparam logic [6:0] VOLT_UPPER_RST = 7'd20;
  localparam logic [7:0] VOLT_LOWER_RST = 8'd20;
  localparam logic [7:0] ROUTERS_RST    = 8'd5;

  localparam logic [7:0] TTL_FULL      = 8'd250;
  localparam logic [7:0] TTL_DROP      = 8'd100;
  localparam logic [7:0] PKT_ABNORMAL  = 8'h00;
  localparam logic [7:0] CUR_SAT       = 8'd255;
  localparam int         NOMINAL_VOLTS = 220;
  localparam int         SCALE         = 100;

  // x / 100 for 16-bit x as (x * 83887) >> 23, exact over the whole range
  localparam logic [16:0] RECIP100  = 17'd83887;
  localparam int          DIV_SHIFT = 23;

  typedef struct packed {
    logic [7:0] ttl;
    logic [7:0] cur;
    logic [9:0] volt;
  } entry_t;

  function automatic logic [9:0] div100(input logic [15:0] x);
    logic [32:0] prod;
    prod = 33'(x) * 33'(RECIP100);
    return prod[DIV_SHIFT+9:DIV_SHIFT];
  endfunction

endpackage

`default_nettype wire

>>> rtl/nrc_ram.sv
`default_nettype none

module nrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/node_reading_cache_with_ttl_aging.sv
`default_nettype none

// Per-node cache of abnormal readings with TTL aging. The accept cycle of a
// command reads the addressed entry from the single cache memory (one read
// port, one write port, registered read), and the following cycle, with busy
// high, modifies and writes it back on an aging step or an update. No command
// is taken while busy. A query result appears on the out_ ports for one cycle,
// flagged by out_valid, in the cycle after busy; it cannot be stalled. Ticks
// and updates give no result. The memory is cleared by per-entry valid flops at
// reset, so the block is ready in the first cycle after reset.
module node_reading_cache_with_ttl_aging #(
  parameter int ENTRIES        = 200,
  parameter int TICKS_PER_STEP = 624
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_node_id,
  input  wire logic [15:0] in_current_raw,
  input  wire logic [15:0] in_voltage_raw,
  input  wire logic [7:0]  in_packet_type,
  // result channel
  output logic             out_valid,
  output logic             out_hit,
  output logic [7:0]       out_ttl_left,
  output logic [14:0]      out_current_value,
  output logic [15:0]      out_voltage_value,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import nrc_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RMW  = 1'b1;

  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_AGE   = 3'd1;
  localparam logic [2:0] K_UPD   = 3'd2;
  localparam logic [2:0] K_QRD   = 3'd3;
  localparam logic [2:0] K_QMISS = 3'd4;

  // configuration registers
  logic [7:0] cur_thresh_r;
  logic [6:0] volt_upper_r;
  logic [7:0] volt_lower_r;
  logic [7:0] routers_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_thresh_r <= CUR_THRESH_RST;
      volt_upper_r <= VOLT_UPPER_RST;
      volt_lower_r <= VOLT_LOWER_RST;
      routers_r    <= ROUTERS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CUR_THRESH: cur_thresh_r <= pwdata[7:0];
        REG_VOLT_UPPER: volt_upper_r <= pwdata[6:0];
        REG_VOLT_LOWER: volt_lower_r <= pwdata[7:0];
        REG_ROUTERS:    routers_r    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CUR_THRESH: prdata = {24'd0, cur_thresh_r};
      REG_VOLT_UPPER: prdata = {25'd0, volt_upper_r};
      REG_VOLT_LOWER: prdata = {24'd0, volt_lower_r};
      REG_ROUTERS:    prdata = {24'd0, routers_r};
      default:        prdata = 32'd0;
    endcase
  end

  // control state
  logic          state_r, state_nxt;
  logic [9:0]    presc_r, presc_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [ENTRIES-1:0] valid_r;
  logic          accept;

  // per-command latches
  logic [2:0]    kind_r;
  logic [AW-1:0] addr_r;
  logic          ent_vld_r;
  logic          cur_ge_r;
  logic          volt_out_r;
  logic [7:0]    cur_q_r;
  logic [9:0]    volt_q_r;

  // accept-cycle decode
  logic [9:0]    presc_inc;
  logic          age_step;
  logic          upd_ok;
  logic          qry_ok;
  logic [AW-1:0] upd_slot;
  logic [AW-1:0] rd_addr;
  logic [2:0]    kind_nxt;
  logic [9:0]    cur_div;
  logic [9:0]    volt_div;
  logic signed [17:0] band_lo, band_hi, volt_s;

  assign busy   = (state_r == ST_RMW);
  assign accept = start && !busy;

  assign presc_inc = presc_r + 10'd1;
  assign age_step  = (presc_inc >= 10'(TICKS_PER_STEP));
  assign upd_ok    = ({1'b0, in_node_id} <= 9'(ENTRIES)) && (in_packet_type == PKT_ABNORMAL);
  assign qry_ok    = (in_node_id != 8'd0) && (in_node_id <= routers_r)
                     && ({1'b0, in_node_id} < 9'(ENTRIES));
  // node id equal to the entry count wraps to slot 0
  assign upd_slot  = ({1'b0, in_node_id} == 9'(ENTRIES)) ? '0 : in_node_id[AW-1:0];

  assign cur_div  = div100(in_current_raw);
  assign volt_div = div100(in_voltage_raw);

  // normal band in raw units; low bound goes negative for large lower margins
  assign band_lo = (18'(NOMINAL_VOLTS) - $signed({10'd0, volt_lower_r})) * 18'(SCALE);
  assign band_hi = (18'(NOMINAL_VOLTS) + $signed({11'd0, volt_upper_r})) * 18'(SCALE);
  assign volt_s  = $signed({2'b00, in_voltage_raw});

  always_comb begin
    rd_addr  = in_node_id[AW-1:0];
    kind_nxt = K_NONE;
    case (in_operation)
      OP_TICK: begin
        rd_addr  = ptr_r;
        kind_nxt = age_step ? K_AGE : K_NONE;
      end
      OP_UPDATE: begin
        rd_addr  = upd_slot;
        kind_nxt = upd_ok ? K_UPD : K_NONE;
      end
      OP_QUERY: begin
        kind_nxt = qry_ok ? K_QRD : K_QMISS;
      end
      default: kind_nxt = K_NONE;
    endcase
  end

  always_comb begin
    presc_nxt = presc_r;
    ptr_nxt   = ptr_r;
    if (accept && (in_operation == OP_TICK)) begin
      presc_nxt = age_step ? 10'd0 : presc_inc;
      if (age_step) begin
        ptr_nxt = (ptr_r == AW'(ENTRIES - 1)) ? '0 : ptr_r + AW'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: state_nxt = accept ? ST_RMW : ST_IDLE;
      ST_RMW:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory and write-back
  entry_t        rd_word;
  entry_t        ent;
  entry_t        wr_word;
  logic          wr_en;

  nrc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_r),
    .wdata (wr_word),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  // entries never written since reset read as zero
  assign ent = ent_vld_r ? rd_word : '0;

  always_comb begin
    wr_word = ent;
    wr_en   = 1'b0;
    if (busy) begin
      case (kind_r)
        K_AGE: begin
          wr_en       = 1'b1;
          wr_word.ttl = (ent.ttl >= TTL_DROP) ? ent.ttl - TTL_DROP : 8'd0;
        end
        K_UPD: begin
          wr_en       = 1'b1;
          wr_word.ttl = TTL_FULL;
          if (cur_ge_r) begin
            wr_word.cur = cur_q_r;
            if (volt_out_r) begin
              wr_word.volt = volt_q_r;
            end
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      presc_r   <= 10'd0;
      ptr_r     <= '0;
      valid_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      presc_r   <= presc_nxt;
      ptr_r     <= ptr_nxt;
      if (wr_en) begin
        valid_r[addr_r] <= 1'b1;
      end
      out_valid <= busy && ((kind_r == K_QRD) || (kind_r == K_QMISS));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= kind_nxt;
      addr_r     <= rd_addr;
      ent_vld_r  <= valid_r[rd_addr];
      cur_ge_r   <= (in_current_raw >= {8'd0, cur_thresh_r});
      volt_out_r <= !((volt_s >= band_lo) && (volt_s <= band_hi));
      cur_q_r    <= (cur_div[9:8] != 2'd0) ? CUR_SAT : cur_div[7:0];
      volt_q_r   <= volt_div;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (busy) begin
      if (kind_r == K_QRD) begin
        out_hit           <= (ent.ttl != 8'd0);
        out_ttl_left      <= ent.ttl;
        out_current_value <= 15'(ent.cur) * 15'(SCALE);
        out_voltage_value <= 16'(ent.volt) * 16'(SCALE);
      end else begin
        out_hit           <= 1'b0;
        out_ttl_left      <= 8'd0;
        out_current_value <= 15'd0;
        out_voltage_value <= 16'd0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $past(start && !busy))
    else $error("busy without an accepted command");

  a_result_after_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat not preceded by a memory cycle");

  a_hit_has_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_ttl_left != 8'd0))
    else $error("hit reported with zero ttl");

  a_ttl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ttl_left <= TTL_FULL))
    else $error("ttl above refresh value");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ptr_r} < (AW + 1)'(ENTRIES))
    else $error("aging pointer out of range");
`endif

endmodule

`default_nettype wire
